[rtl/core/assert_macros.svh]
// Assertion macros shared by the fill engine RTL.
// Needs a clk and an active-low rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every rising edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/core/crcf_pkg.sv]
// Shared types and constants for the clipped rectangle / circle fill engine.
// No dependencies; every RTL module file refers to this package by scope.
package crcf_pkg;

    // Frame store size
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XC_W       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YC_W       = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int EW_W       = $clog2(MAX_WIDTH + 1);
    localparam int EH_W       = $clog2(MAX_HEIGHT + 1);

    // Field widths
    localparam int OP_W        = 2;
    localparam int COORD_IN_W  = 16;
    localparam int COLOR_W     = 32;
    localparam int PIX_W       = 24;
    localparam int COUNT_W     = 17;
    localparam int CFG_W       = 9;
    localparam int CFG_INDEX_W = 1;

    // Internal arithmetic widths
    localparam int CW     = COORD_IN_W + 2;    // corner math incl. x + 2r
    localparam int SQ_W   = COORD_IN_W + 1;    // offsets from the circle center
    localparam int D2_W   = 2 * COORD_IN_W;    // squared distances and limit
    localparam int MUL_AW = ((YC_W > EW_W) ? YC_W : EW_W) + 1;
    localparam int MUL_W  = (SQ_W > MUL_AW) ? SQ_W : MUL_AW;

    // Command queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Operation codes
    localparam logic [OP_W-1:0] OP_RECT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CIRCLE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] SCREEN_WIDTH_RESET  = 9'd256;
    localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RESET = 9'd256;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_RECT,
        KIND_CIRCLE,
        KIND_READ
    } kind_t;

    typedef struct packed {
        logic [OP_W-1:0]              operation;
        logic signed [COORD_IN_W-1:0] x_first;
        logic signed [COORD_IN_W-1:0] y_first;
        logic signed [COORD_IN_W-1:0] x_second;
        logic signed [COORD_IN_W-1:0] y_second;
        logic signed [COORD_IN_W-1:0] radius;
        logic [COLOR_W-1:0]           fill_color;
    } item_t;

    typedef struct packed {
        logic [PIX_W-1:0]   read_data;
        logic [COUNT_W-1:0] pixels_written;
    } result_t;

    // Classified command, as handed from front to back
    typedef struct packed {
        kind_t                  kind;
        logic [XC_W-1:0]        x0;
        logic [XC_W-1:0]        x1;
        logic [YC_W-1:0]        y0;
        logic [YC_W-1:0]        y1;
        logic [EW_W-1:0]        width;
        logic [EW_W-1:0]        row_skip;
        logic signed [SQ_W-1:0] dx0;
        logic signed [SQ_W-1:0] dy0;
        logic [COORD_IN_W-1:0]  radius;
        logic [PIX_W-1:0]       color;
    } desc_t;

endpackage

[rtl/core/clipped_rect_circle_fill.sv]
// Top level of the clipped rectangle / circle fill engine.
// Depends on crcf_pkg, crcf_front, crcf_queue and crcf_back.
//
//   port group                     direction  handshake
//   item (command)                 in         start, accepted when !busy
//   result (read data, count)      out        done, one cycle, no stall
//   wr_en / wr_index / wr_data     in         write on every wr_en edge
//
// After reset the frame store is cleared one pixel a cycle: busy stays high
// until all MAX_WIDTH*MAX_HEIGHT = 65536 pixels are cleared. A rectangle is
// drawn pixel by pixel over its clipped box, a circle over its clipped
// bounding box; a read fetches one pixel. The single frame store port is
// shared by the clearing pass, the one pixel-per-cycle walker and the read
// path. A two-entry queue lets a new command be taken while the previous one is still drawing.
module clipped_rect_circle_fill (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  crcf_pkg::item_t                  item,
    output logic                             done,
    output crcf_pkg::result_t                result,
    input  logic                             wr_en,
    input  logic [crcf_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [crcf_pkg::CFG_W-1:0]       wr_data
);

    logic            clearing;
    logic            q_full;
    logic            q_empty;
    logic            push;
    logic            pop;
    crcf_pkg::desc_t push_data;
    crcf_pkg::desc_t pop_data;

    crcf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .start     (start),
        .item      (item),
        .busy      (busy),
        .clearing  (clearing),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    crcf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    crcf_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_data   (pop_data),
        .pop      (pop),
        .clearing (clearing),
        .done     (done),
        .result   (result)
    );

endmodule

[rtl/core/crcf_front.sv]
// Front end: screen size registers, command intake and classification.
// Depends on crcf_pkg; feeds classified commands to crcf_queue.
module crcf_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [crcf_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [crcf_pkg::CFG_W-1:0]       wr_data,
    input  logic                             start,
    input  crcf_pkg::item_t                  item,
    output logic                             busy,
    input  logic                             clearing,
    input  logic                             q_full,
    output logic                             push,
    output crcf_pkg::desc_t                  push_data
);

    logic [crcf_pkg::CFG_W-1:0] width_reg;
    logic [crcf_pkg::CFG_W-1:0] height_reg;
    logic                       valid_reg;
    crcf_pkg::item_t            item_reg;

    logic [crcf_pkg::EW_W-1:0]       eff_w;
    logic [crcf_pkg::EH_W-1:0]       eff_h;
    logic signed [crcf_pkg::CW-1:0]  w_s, h_s;
    logic signed [crcf_pkg::CW-1:0]  xa, ya, xb, yb, rr;
    logic signed [crcf_pkg::CW-1:0]  lo_x, hi_x, lo_y, hi_y;
    logic signed [crcf_pkg::CW-1:0]  x0c, x1c, y0c, y1c;
    logic                            box_empty;
    logic                            on_screen;
    logic                            accept;

    assign accept = start && !busy;
    assign busy   = clearing || (valid_reg && q_full);
    assign push   = valid_reg && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= crcf_pkg::SCREEN_WIDTH_RESET;
            height_reg <= crcf_pkg::SCREEN_HEIGHT_RESET;
            valid_reg  <= 1'b0;
            item_reg   <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    crcf_pkg::REG_SCREEN_WIDTH:  width_reg  <= wr_data;
                    crcf_pkg::REG_SCREEN_HEIGHT: height_reg <= wr_data;
                    default: ;
                endcase
            end
            if (accept)
            begin
                valid_reg <= 1'b1;
                item_reg  <= item;
            end
            else if (push)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Clamp oversize screen to the store size
    always_comb
    begin
        if (32'(width_reg) > crcf_pkg::MAX_WIDTH)
            eff_w = crcf_pkg::EW_W'(crcf_pkg::MAX_WIDTH);
        else
            eff_w = crcf_pkg::EW_W'(width_reg);
        if (32'(height_reg) > crcf_pkg::MAX_HEIGHT)
            eff_h = crcf_pkg::EH_W'(crcf_pkg::MAX_HEIGHT);
        else
            eff_h = crcf_pkg::EH_W'(height_reg);
    end

    always_comb
    begin
        w_s = crcf_pkg::CW'(eff_w);
        h_s = crcf_pkg::CW'(eff_h);
        xa  = crcf_pkg::CW'(item_reg.x_first);
        ya  = crcf_pkg::CW'(item_reg.y_first);
        xb  = crcf_pkg::CW'(item_reg.x_second);
        yb  = crcf_pkg::CW'(item_reg.y_second);
        rr  = crcf_pkg::CW'(item_reg.radius);

        if (item_reg.operation == crcf_pkg::OP_CIRCLE)
        begin
            lo_x = xa;
            lo_y = ya;
            hi_x = xa + rr + rr;
            hi_y = ya + rr + rr;
        end
        else
        begin
            lo_x = (xa < xb) ? xa : xb;
            hi_x = (xa < xb) ? xb : xa;
            lo_y = (ya < yb) ? ya : yb;
            hi_y = (ya < yb) ? yb : ya;
        end

        x0c = (lo_x < 0) ? '0 : lo_x;
        y0c = (lo_y < 0) ? '0 : lo_y;
        x1c = (hi_x > w_s - 1) ? w_s - 1 : hi_x;
        y1c = (hi_y > h_s - 1) ? h_s - 1 : hi_y;
        box_empty = (x0c > x1c) || (y0c > y1c);
        on_screen = (xa >= 0) && (ya >= 0) && (xa < w_s) && (ya < h_s);

        push_data.x0       = crcf_pkg::XC_W'(x0c);
        push_data.x1       = crcf_pkg::XC_W'(x1c);
        push_data.y0       = crcf_pkg::YC_W'(y0c);
        push_data.y1       = crcf_pkg::YC_W'(y1c);
        push_data.width    = eff_w;
        push_data.row_skip = crcf_pkg::EW_W'(w_s - x1c + x0c);
        push_data.dx0      = crcf_pkg::SQ_W'(x0c - xa - rr);
        push_data.dy0      = crcf_pkg::SQ_W'(y0c - ya - rr);
        push_data.radius   = item_reg.radius;
        push_data.color    = item_reg.fill_color[crcf_pkg::COLOR_W-1 -: crcf_pkg::PIX_W];

        case (item_reg.operation)
            crcf_pkg::OP_RECT:
                push_data.kind = box_empty ? crcf_pkg::KIND_NONE : crcf_pkg::KIND_RECT;
            crcf_pkg::OP_CIRCLE:
                push_data.kind = (box_empty || rr < 0) ? crcf_pkg::KIND_NONE
                                                       : crcf_pkg::KIND_CIRCLE;
            crcf_pkg::OP_READ:
            begin
                push_data.kind = on_screen ? crcf_pkg::KIND_READ : crcf_pkg::KIND_NONE;
                push_data.x0   = crcf_pkg::XC_W'(xa);
                push_data.y0   = crcf_pkg::YC_W'(ya);
            end
            default:
                push_data.kind = crcf_pkg::KIND_NONE;
        endcase
    end

endmodule

[rtl/core/crcf_queue.sv]
// Short command queue between the front end and the draw engine.
// Depends on crcf_pkg for the command type and depth.
`include "assert_macros.svh"

module crcf_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  crcf_pkg::desc_t push_data,
    output logic            full,
    input  logic            pop,
    output crcf_pkg::desc_t pop_data,
    output logic            empty
);

    crcf_pkg::desc_t                slot_reg [crcf_pkg::QUEUE_DEPTH];
    logic [crcf_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [crcf_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [crcf_pkg::QCNT_W-1:0]    count_reg;

    localparam logic [crcf_pkg::QPTR_W-1:0] PTR_LAST =
        crcf_pkg::QPTR_W'(crcf_pkg::QUEUE_DEPTH - 1);
    localparam logic [crcf_pkg::QCNT_W-1:0] CNT_FULL =
        crcf_pkg::QCNT_W'(crcf_pkg::QUEUE_DEPTH);

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    `ASSERT_IMPL(a_q_no_underflow, pop, count_reg != '0, "queue popped while empty")
    `ASSERT_IMPL(a_q_no_overflow, push, count_reg != CNT_FULL, "queue pushed while full")
    `ASSERT_ALWAYS(a_q_count_range, count_reg <= CNT_FULL, "queue count out of range")

endmodule

[rtl/core/crcf_back.sv]
// Draw engine: frame store, clearing pass, pixel walker and read path.
// Depends on crcf_pkg; takes classified commands from crcf_queue.
`include "assert_macros.svh"

module crcf_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  crcf_pkg::desc_t   q_data,
    output logic              pop,
    output logic              clearing,
    output logic              done,
    output crcf_pkg::result_t result
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BASE,
        ST_ADDR,
        ST_SQ_R,
        ST_SQ_DX,
        ST_SQ_DY,
        ST_SUM,
        ST_DRAW,
        ST_READ,
        ST_RDOUT
    } state_t;

    localparam logic [crcf_pkg::ADDR_W-1:0] ADDR_LAST =
        crcf_pkg::ADDR_W'(crcf_pkg::DEPTH - 1);

    logic [crcf_pkg::PIX_W-1:0] mem [crcf_pkg::DEPTH];

    state_t                          state_reg;
    crcf_pkg::desc_t                 cur_reg;
    logic [crcf_pkg::ADDR_W-1:0]     addr_reg;
    logic [crcf_pkg::XC_W-1:0]       x_reg;
    logic [crcf_pkg::YC_W-1:0]       y_reg;
    logic signed [crcf_pkg::SQ_W-1:0] dx_reg;
    logic signed [crcf_pkg::SQ_W-1:0] dy_reg;
    logic [crcf_pkg::D2_W-1:0]       d2_reg;
    logic [crcf_pkg::D2_W-1:0]       row_d2_reg;
    logic [crcf_pkg::D2_W-1:0]       lim_reg;
    logic [crcf_pkg::COUNT_W-1:0]    cnt_reg;
    logic [crcf_pkg::PIX_W-1:0]      rd_data_reg;
    logic                            done_reg;
    crcf_pkg::result_t               result_reg;

    logic signed [crcf_pkg::MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*crcf_pkg::MUL_W-1:0] product;
    logic                                hit;
    logic                                wr_en;
    logic [crcf_pkg::PIX_W-1:0]          wr_pix;
    logic [crcf_pkg::D2_W-1:0]           dx_step, dy_step, row_d2_sum;

    assign pop      = (state_reg == ST_IDLE) && !q_empty;
    assign clearing = (state_reg == ST_CLEAR);
    assign done     = done_reg;
    assign result   = result_reg;

    assign hit    = (cur_reg.kind == crcf_pkg::KIND_RECT) || (d2_reg <= lim_reg);
    assign wr_en  = (state_reg == ST_CLEAR) || ((state_reg == ST_DRAW) && hit);
    assign wr_pix = (state_reg == ST_CLEAR) ? '0 : cur_reg.color;

    // Odd steps 2*d+1 between consecutive squares
    assign dx_step = {{(crcf_pkg::D2_W-crcf_pkg::SQ_W-1){dx_reg[crcf_pkg::SQ_W-1]}},
                      dx_reg, 1'b1};
    assign dy_step = {{(crcf_pkg::D2_W-crcf_pkg::SQ_W-1){dy_reg[crcf_pkg::SQ_W-1]}},
                      dy_reg, 1'b1};
    assign row_d2_sum = row_d2_reg + dy_step;

    // One shared multiplier for row base and the squares
    always_comb
    begin
        unique case (state_reg)
            ST_SQ_R:
            begin
                mul_a = crcf_pkg::MUL_W'(cur_reg.radius);
                mul_b = crcf_pkg::MUL_W'(cur_reg.radius);
            end
            ST_SQ_DX:
            begin
                mul_a = crcf_pkg::MUL_W'(cur_reg.dx0);
                mul_b = crcf_pkg::MUL_W'(cur_reg.dx0);
            end
            ST_SQ_DY:
            begin
                mul_a = crcf_pkg::MUL_W'(cur_reg.dy0);
                mul_b = crcf_pkg::MUL_W'(cur_reg.dy0);
            end
            default:
            begin
                mul_a = crcf_pkg::MUL_W'(cur_reg.y0);
                mul_b = crcf_pkg::MUL_W'(cur_reg.width);
            end
        endcase
        product = mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            cur_reg    <= '0;
            addr_reg   <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
            dx_reg     <= '0;
            dy_reg     <= '0;
            d2_reg     <= '0;
            row_d2_reg <= '0;
            lim_reg    <= '0;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_CLEAR:
                begin
                    addr_reg <= addr_reg + 1'b1;
                    if (addr_reg == ADDR_LAST)
                        state_reg <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        cur_reg <= q_data;
                        cnt_reg <= '0;
                        x_reg   <= q_data.x0;
                        y_reg   <= q_data.y0;
                        if (q_data.kind == crcf_pkg::KIND_NONE)
                        begin
                            done_reg   <= 1'b1;
                            result_reg <= '0;
                        end
                        else
                        begin
                            state_reg <= ST_BASE;
                        end
                    end
                end
                ST_BASE:
                begin
                    addr_reg  <= crcf_pkg::ADDR_W'(product);
                    state_reg <= ST_ADDR;
                end
                ST_ADDR:
                begin
                    addr_reg <= addr_reg + crcf_pkg::ADDR_W'(cur_reg.x0);
                    unique case (cur_reg.kind)
                        crcf_pkg::KIND_RECT:   state_reg <= ST_DRAW;
                        crcf_pkg::KIND_CIRCLE: state_reg <= ST_SQ_R;
                        default:               state_reg <= ST_READ;
                    endcase
                end
                ST_SQ_R:
                begin
                    lim_reg   <= crcf_pkg::D2_W'(product);
                    state_reg <= ST_SQ_DX;
                end
                ST_SQ_DX:
                begin
                    d2_reg    <= crcf_pkg::D2_W'(product);
                    lim_reg   <= lim_reg + crcf_pkg::D2_W'(cur_reg.radius);
                    state_reg <= ST_SQ_DY;
                end
                ST_SQ_DY:
                begin
                    row_d2_reg <= crcf_pkg::D2_W'(product);
                    dx_reg     <= cur_reg.dx0;
                    dy_reg     <= cur_reg.dy0;
                    state_reg  <= ST_SUM;
                end
                ST_SUM:
                begin
                    d2_reg     <= d2_reg + row_d2_reg;
                    row_d2_reg <= d2_reg + row_d2_reg;
                    state_reg  <= ST_DRAW;
                end
                ST_DRAW:
                begin
                    if (hit)
                        cnt_reg <= cnt_reg + 1'b1;
                    if (x_reg == cur_reg.x1)
                    begin
                        if (y_reg == cur_reg.y1)
                        begin
                            done_reg                  <= 1'b1;
                            result_reg.read_data      <= '0;
                            result_reg.pixels_written <= cnt_reg + crcf_pkg::COUNT_W'(hit);
                            state_reg                 <= ST_IDLE;
                        end
                        else
                        begin
                            // wrap to the start of the next row
                            x_reg      <= cur_reg.x0;
                            y_reg      <= y_reg + 1'b1;
                            addr_reg   <= addr_reg + crcf_pkg::ADDR_W'(cur_reg.row_skip);
                            dx_reg     <= cur_reg.dx0;
                            dy_reg     <= dy_reg + crcf_pkg::SQ_W'(1);
                            row_d2_reg <= row_d2_sum;
                            d2_reg     <= row_d2_sum;
                        end
                    end
                    else
                    begin
                        x_reg    <= x_reg + 1'b1;
                        addr_reg <= addr_reg + 1'b1;
                        dx_reg   <= dx_reg + crcf_pkg::SQ_W'(1);
                        d2_reg   <= d2_reg + dx_step;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_RDOUT;
                end
                ST_RDOUT:
                begin
                    done_reg                  <= 1'b1;
                    result_reg.read_data      <= rd_data_reg;
                    result_reg.pixels_written <= '0;
                    state_reg                 <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[addr_reg] <= wr_pix;
        rd_data_reg <= mem[addr_reg];
    end

    `ASSERT_IMPL(a_done_in_idle, done_reg, state_reg == ST_IDLE, "result strobe outside idle")
    `ASSERT_IMPL(a_draw_x_in_box, state_reg == ST_DRAW,
        (x_reg >= cur_reg.x0) && (x_reg <= cur_reg.x1), "walker x left the clipped box")
    `ASSERT_IMPL(a_draw_y_in_box, state_reg == ST_DRAW,
        (y_reg >= cur_reg.y0) && (y_reg <= cur_reg.y1), "walker y left the clipped box")

endmodule
